/* design/ccd_pkg.sv */
package ccd_pkg;

  // Default number of output channels.
  localparam int unsigned CHANNELS_DEF = 27;

  // Command opcodes carried in payload byte 0.
  localparam logic [7:0] OP_START     = 8'h10;
  localparam logic [7:0] OP_STOP      = 8'h11;
  localparam logic [7:0] OP_SPEED     = 8'h12;
  localparam logic [7:0] OP_DIRECTION = 8'h13;
  localparam logic [7:0] OP_ESTOP     = 8'h14;
  localparam logic [7:0] OP_PING      = 8'h15;

  localparam logic [7:0] DUTY_FULL = 8'd255;

  // Drive change codes.
  localparam logic [1:0] DRIVE_NONE = 2'd0;
  localparam logic [1:0] DRIVE_ONE  = 2'd1;
  localparam logic [1:0] DRIVE_ALL  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_BASE = 2'd2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [7:0]  NODE_ID_RST  = 8'd1;
  localparam logic [10:0] CMD_BASE_RST = 11'd256;
  localparam logic [10:0] ACK_BASE_RST = 11'd512;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [7:0]  opcode;
    logic [7:0]  channel;
    logic [7:0]  value_low;
    logic [7:0]  value_high;
  } ccd_in_t;

  typedef struct packed {
    logic        addressed;
    logic        ack_valid;
    logic [10:0] ack_id;
    logic [7:0]  ack_opcode;
    logic [7:0]  ack_channel;
    logic [7:0]  ack_value;
    logic [1:0]  drive_kind;
    logic [4:0]  drive_channel;
    logic [7:0]  drive_duty;
    logic [15:0] stored_value;
    logic [31:0] frame_total;
    logic [31:0] wrong_id_total;
  } ccd_out_t;

  typedef struct packed {
    logic [7:0]  node_id;
    logic [10:0] cmd_base;
    logic [10:0] ack_base;
  } ccd_cfg_t;

  // Channel store update requested by one frame.
  typedef struct packed {
    logic        wr;
    logic        clr_all;
    logic [15:0] value;
  } ccd_upd_t;

endpackage

/* design/can_channel_command_decoder_top.sv */
// Channel   Handshake                Payload
// in        in_valid_i / in_ready_o  in_data_i (ccd_in_t), one received frame
// out       out_valid_o/ out_ready_i out_data_o (ccd_out_t), one result per frame
// cfg       cfg_valid_i/ cfg_ready_o cfg_idx_i, cfg_data_i, always ready
//
// From transfer to result each frame passes an input register, then the decode and
// channel store update into the result register. A new frame is taken every cycle
// unless the output stalls; the rate is set by the single decode stage.
// Reset clears the channel values and counters and loads the default identifiers.
// A stalled output holds its result, and the input stage fills before in_ready_o drops.
module can_channel_command_decoder_top import ccd_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ccd_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ccd_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  ccd_cfg_t    cfg_q;
  logic        s1_valid_q;
  ccd_in_t     s1_q;
  logic        out_valid_q;
  ccd_out_t    out_q;
  logic [15:0] values_q [CHANNELS];
  logic [31:0] frames_q;
  logic [31:0] wrong_q;

  logic        s1_adv;
  logic        in_fire;
  logic        s1_in_range;
  logic [CH_W-1:0] s1_idx;
  logic [15:0] cur_value;
  ccd_out_t    res;
  ccd_upd_t    upd;

  assign cfg_ready_o = 1'b1;
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign s1_in_range = s1_q.channel < 8'(CHANNELS);
  assign s1_idx      = s1_q.channel[CH_W-1:0];
  assign cur_value   = s1_in_range ? values_q[s1_idx] : 16'd0;

  ccd_decode #(
    .CHANNELS(CHANNELS)
  ) u_decode (
    .item_i     (s1_q),
    .cfg_i      (cfg_q),
    .cur_value_i(cur_value),
    .frames_i   (frames_q),
    .wrong_i    (wrong_q),
    .res_o      (res),
    .upd_o      (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_id  <= NODE_ID_RST;
      cfg_q.cmd_base <= CMD_BASE_RST;
      cfg_q.ack_base <= ACK_BASE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        CFG_NODE_ID:  cfg_q.node_id  <= cfg_data_i[7:0];
        CFG_CMD_BASE: cfg_q.cmd_base <= cfg_data_i;
        CFG_ACK_BASE: cfg_q.ack_base <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      frames_q    <= 32'd0;
      wrong_q     <= 32'd0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        frames_q    <= res.frame_total;
        wrong_q     <= res.wrong_id_total;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_data_i;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  // Channel store: at most one entry written per frame, or all cleared on emergency stop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        values_q[i] <= 16'd0;
      end
    end else if (s1_adv) begin
      if (upd.clr_all) begin
        for (int i = 0; i < CHANNELS; i++) begin
          values_q[i] <= 16'd0;
        end
      end else if (upd.wr) begin
        values_q[s1_idx] <= upd.value;
      end
    end
  end

  a_frame_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> frames_q == $past(frames_q) + 32'd1)
    else $error("frame counter did not advance by one");

  a_ack_addressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.ack_valid || out_q.drive_kind != DRIVE_NONE) |-> out_q.addressed)
    else $error("acknowledge or drive change for a frame of another node");

  a_wrong_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (wrong_q == $past(wrong_q)) == out_q.addressed)
    else $error("wrong-ID counter out of step with address match");

  a_estop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && upd.clr_all |=> values_q[0] == 16'd0)
    else $error("emergency stop left a channel value");

  a_stall_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while both stages are full and stalled");

endmodule

/* design/ccd_decode.sv */
module ccd_decode import ccd_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  ccd_in_t     item_i,
  input  ccd_cfg_t    cfg_i,
  input  logic [15:0] cur_value_i,
  input  logic [31:0] frames_i,
  input  logic [31:0] wrong_i,
  output ccd_out_t    res_o,
  output ccd_upd_t    upd_o
);

  logic        addressed;
  logic        in_range;
  logic [15:0] val;
  logic [7:0]  duty;
  logic [11:0] cmd_id;

  // The command identifier is compared at 12 bits so that a sum above 2047 never matches.
  assign cmd_id    = {1'b0, cfg_i.cmd_base} + {4'b0, cfg_i.node_id};
  assign addressed = {1'b0, item_i.frame_id} == cmd_id;
  assign in_range  = item_i.channel < 8'(CHANNELS);
  assign val       = {item_i.value_high, item_i.value_low};
  assign duty      = (val[15:8] != 8'd0) ? DUTY_FULL : val[7:0];

  always_comb begin
    res_o                = '0;
    upd_o                = '0;
    res_o.addressed      = addressed;
    res_o.frame_total    = frames_i + 32'd1;
    res_o.wrong_id_total = addressed ? wrong_i : wrong_i + 32'd1;
    if (addressed) begin
      unique case (item_i.opcode)
        OP_START, OP_SPEED: begin
          if (in_range) begin
            upd_o.wr            = 1'b1;
            upd_o.value         = val;
            res_o.drive_kind    = DRIVE_ONE;
            res_o.drive_channel = item_i.channel[4:0];
            res_o.drive_duty    = duty;
            res_o.ack_valid     = 1'b1;
            res_o.ack_opcode    = item_i.opcode;
            res_o.ack_channel   = item_i.channel;
            res_o.ack_value     = duty;
          end
        end
        OP_STOP: begin
          if (in_range) begin
            upd_o.wr            = 1'b1;
            res_o.drive_kind    = DRIVE_ONE;
            res_o.drive_channel = item_i.channel[4:0];
            res_o.ack_valid     = 1'b1;
            res_o.ack_opcode    = item_i.opcode;
            res_o.ack_channel   = item_i.channel;
          end
        end
        OP_DIRECTION: begin
          if (in_range) begin
            res_o.ack_valid   = 1'b1;
            res_o.ack_opcode  = item_i.opcode;
            res_o.ack_channel = item_i.channel;
            res_o.ack_value   = item_i.value_low;
          end
        end
        OP_ESTOP: begin
          upd_o.clr_all    = 1'b1;
          res_o.drive_kind = DRIVE_ALL;
        end
        OP_PING: begin
          res_o.ack_valid  = 1'b1;
          res_o.ack_opcode = item_i.opcode;
        end
        default: begin
        end
      endcase
      if (in_range) begin
        if (upd_o.wr || upd_o.clr_all) begin
          res_o.stored_value = upd_o.value;
        end else begin
          res_o.stored_value = cur_value_i;
        end
      end
    end
    if (res_o.ack_valid) begin
      res_o.ack_id = cfg_i.ack_base + {3'b0, cfg_i.node_id};
    end
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
  import ccd_pkg::*;

  localparam int unsigned CHANNELS = CHANNELS_DEF;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  ccd_in_t               in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  ccd_out_t              out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  can_channel_command_decoder_top #(
    .CHANNELS(CHANNELS)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Frames waiting to be offered and decoded results waiting to come out.
  ccd_in_t  frame_q[$];
  ccd_out_t decoded_q[$];

  // Shadow of the node's registers and channel store.
  logic [7:0]  my_node = NODE_ID_RST;
  logic [10:0] my_cmd_base = CMD_BASE_RST;
  logic [10:0] my_ack_base = ACK_BASE_RST;
  logic [15:0] chan_val[CHANNELS];
  logic [31:0] frames_seen = '0;
  logic [31:0] frames_not_mine = '0;

  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req_id = 0;
  int unsigned hold_seen_id = 0;
  int unsigned hold_left = 0;

  initial begin
    foreach (chan_val[i]) chan_val[i] = '0;
  end

  function automatic ccd_out_t decode_frame(input ccd_in_t f);
    ccd_out_t    r;
    logic [15:0] val;
    logic [7:0]  duty;
    logic        in_range;
    logic        ack;
    logic [7:0]  a_ch;
    logic [7:0]  a_val;
    r = '0;
    ack = 1'b0;
    a_ch = '0;
    a_val = '0;
    val = {f.value_high, f.value_low};
    duty = (val > 16'(DUTY_FULL)) ? DUTY_FULL : val[7:0];
    in_range = f.channel < CHANNELS;
    frames_seen = frames_seen + 1;
    // The command identifier is compared at full width, so a sum past 11 bits never matches.
    r.addressed = ({1'b0, f.frame_id} == ({1'b0, my_cmd_base} + {4'b0, my_node}));
    if (!r.addressed) begin
      frames_not_mine = frames_not_mine + 1;
    end else begin
      case (f.opcode)
        OP_START, OP_SPEED: begin
          if (in_range) begin
            chan_val[f.channel] = val;
            r.drive_kind = DRIVE_ONE;
            r.drive_channel = f.channel[4:0];
            r.drive_duty = duty;
            ack = 1'b1;
            a_ch = f.channel;
            a_val = duty;
          end
        end
        OP_STOP: begin
          if (in_range) begin
            chan_val[f.channel] = '0;
            r.drive_kind = DRIVE_ONE;
            r.drive_channel = f.channel[4:0];
            ack = 1'b1;
            a_ch = f.channel;
          end
        end
        OP_DIRECTION: begin
          if (in_range) begin
            ack = 1'b1;
            a_ch = f.channel;
            a_val = f.value_low;
          end
        end
        OP_ESTOP: begin
          foreach (chan_val[i]) chan_val[i] = '0;
          r.drive_kind = DRIVE_ALL;
        end
        OP_PING: ack = 1'b1;
        default: ;
      endcase
      if (in_range) r.stored_value = chan_val[f.channel];
    end
    if (ack) begin
      r.ack_valid = 1'b1;
      r.ack_id = 11'(my_ack_base + my_node);
      r.ack_opcode = f.opcode;
      r.ack_channel = a_ch;
      r.ack_value = a_val;
    end
    r.frame_total = frames_seen;
    r.wrong_id_total = frames_not_mine;
    return r;
  endfunction

  function automatic logic [10:0] my_cmd_id();
    return 11'(my_cmd_base + my_node);
  endfunction

  function automatic ccd_in_t make_frame(input logic [10:0] fid, input logic [7:0] op,
                                         input logic [7:0] ch, input logic [15:0] val);
    ccd_in_t f;
    f.frame_id = fid;
    f.opcode = op;
    f.channel = ch;
    f.value_low = val[7:0];
    f.value_high = val[15:8];
    return f;
  endfunction

  // Mostly well-formed commands for this node, with some noise on the bus.
  function automatic ccd_in_t random_frame();
    ccd_in_t     f;
    int unsigned op_pick;
    f.frame_id = ($urandom_range(99) < 80) ? my_cmd_id() : 11'($urandom_range(2047));
    op_pick = $urandom_range(15);
    if (op_pick < 4) f.opcode = OP_START;
    else if (op_pick < 6) f.opcode = OP_STOP;
    else if (op_pick < 10) f.opcode = OP_SPEED;
    else if (op_pick < 12) f.opcode = OP_DIRECTION;
    else if (op_pick < 13) f.opcode = OP_ESTOP;
    else if (op_pick < 15) f.opcode = OP_PING;
    else f.opcode = 8'($urandom_range(255));
    f.channel = ($urandom_range(99) < 85) ? 8'($urandom_range(CHANNELS - 1))
                                          : 8'($urandom_range(255));
    f.value_low = 8'($urandom_range(255));
    f.value_high = ($urandom_range(99) < 40) ? 8'd0 : 8'($urandom_range(255));
    return f;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] got,
                                      input logic [31:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_NODE_ID:  my_node = data[7:0];
      CFG_CMD_BASE: my_cmd_base = data;
      CFG_ACK_BASE: my_ack_base = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // Every frame yields a result, so the block is idle once the last one is out.
  task automatic wait_drained();
    while (frame_q.size() != 0 || in_valid_i || decoded_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic push_random(input int unsigned count);
    repeat (count) frame_q.push_back(random_frame());
  endtask

  // Frame driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= frame_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver; a new hold-off request keeps ready low for a long stretch.
  always @(posedge clk_i) begin
    if (hold_seen_id != hold_req_id) begin
      hold_seen_id <= hold_req_id;
      hold_left <= HOLD_OFF_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result check first: a frame accepted at this edge cannot come out at the same edge.
  always @(posedge clk_i) begin : result_check
    ccd_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual %h",
                   $time, out_data_o);
          err_count++;
        end else begin
          want = decoded_q.pop_front();
          check_field("addressed", 32'(out_data_o.addressed), 32'(want.addressed));
          check_field("ack_valid", 32'(out_data_o.ack_valid), 32'(want.ack_valid));
          check_field("ack_id", 32'(out_data_o.ack_id), 32'(want.ack_id));
          check_field("ack_opcode", 32'(out_data_o.ack_opcode), 32'(want.ack_opcode));
          check_field("ack_channel", 32'(out_data_o.ack_channel), 32'(want.ack_channel));
          check_field("ack_value", 32'(out_data_o.ack_value), 32'(want.ack_value));
          check_field("drive_kind", 32'(out_data_o.drive_kind), 32'(want.drive_kind));
          check_field("drive_channel", 32'(out_data_o.drive_channel),
                      32'(want.drive_channel));
          check_field("drive_duty", 32'(out_data_o.drive_duty), 32'(want.drive_duty));
          check_field("stored_value", 32'(out_data_o.stored_value), 32'(want.stored_value));
          check_field("frame_total", out_data_o.frame_total, want.frame_total);
          check_field("wrong_id_total", out_data_o.wrong_id_total, want.wrong_id_total);
        end
      end
      if (in_valid_i && in_ready_o) decoded_q.push_back(decode_frame(in_data_i));
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [10:0] me;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Registers at their reset values; sender idles lightly, receiver heavily.
    send_idle_pct = 25;
    recv_idle_pct = 49;
    me = my_cmd_id();
    frame_q.push_back(make_frame(me, OP_START, 8'd0, 16'h0000));
    frame_q.push_back(make_frame(me, OP_START, 8'd26, 16'hFFFF));
    frame_q.push_back(make_frame(me, OP_SPEED, 8'd5, 16'h00FF));
    frame_q.push_back(make_frame(me, OP_SPEED, 8'd5, 16'h0100));
    frame_q.push_back(make_frame(me, OP_STOP, 8'd26, 16'hFFFF));
    frame_q.push_back(make_frame(me, OP_DIRECTION, 8'd3, 16'h5AA5));
    frame_q.push_back(make_frame(me, OP_DIRECTION, 8'd0, 16'hFF00));
    frame_q.push_back(make_frame(me, OP_DIRECTION, 8'd27, 16'h0001));
    frame_q.push_back(make_frame(me, OP_START, 8'd27, 16'h1234));
    frame_q.push_back(make_frame(me, OP_STOP, 8'd255, 16'h0000));
    frame_q.push_back(make_frame(me, OP_SPEED, 8'd128, 16'h00AA));
    frame_q.push_back(make_frame(me, OP_PING, 8'd200, 16'hFFFF));
    frame_q.push_back(make_frame(me, OP_SPEED, 8'd12, 16'h7FFF));
    frame_q.push_back(make_frame(me, OP_ESTOP, 8'd255, 16'hFFFF));
    frame_q.push_back(make_frame(me, OP_SPEED, 8'd12, 16'h8000));
    frame_q.push_back(make_frame(me, 8'h00, 8'd5, 16'h1111));
    frame_q.push_back(make_frame(me, 8'hFF, 8'd5, 16'h2222));
    frame_q.push_back(make_frame(me, 8'h0F, 8'd1, 16'h0033));
    frame_q.push_back(make_frame(me, 8'h16, 8'd1, 16'h0044));
    frame_q.push_back(make_frame(11'd0, OP_START, 8'd1, 16'h0055));
    frame_q.push_back(make_frame(11'd2047, OP_ESTOP, 8'd0, 16'h0000));
    frame_q.push_back(make_frame(me + 11'd1, OP_SPEED, 8'd12, 16'h0066));
    frame_q.push_back(make_frame(me - 11'd1, OP_STOP, 8'd12, 16'h0000));
    frame_q.push_back(make_frame(me, OP_STOP, 8'd12, 16'hFFFF));
    push_random(500);
    wait_drained();

    // Everything at zero: command and acknowledge identifiers both at the bottom.
    write_reg(CFG_NODE_ID, 11'd0);
    write_reg(CFG_CMD_BASE, 11'd0);
    write_reg(CFG_ACK_BASE, 11'd0);
    @(negedge clk_i);
    send_idle_pct = 49;
    recv_idle_pct = 25;
    push_random(450);
    // Long receiver stall while frames keep coming, so the input side backs up.
    hold_req_id = hold_req_id + 1;
    wait_drained();

    // Node id written with bits above its width; command id lands exactly on 2047,
    // the acknowledge id wraps past 11 bits, and a write to an unused index is dropped.
    write_reg(CFG_NODE_ID, 11'h7FF);
    write_reg(CFG_CMD_BASE, 11'd1792);
    write_reg(CFG_ACK_BASE, 11'd2047);
    write_reg(CFG_UNUSED, 11'($urandom_range(2047)));
    @(negedge clk_i);
    push_random(450);
    wait_drained();

    // The command id sum overflows 11 bits and must never match its truncation.
    write_reg(CFG_CMD_BASE, 11'd2047);
    @(negedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    me = my_cmd_id();
    frame_q.push_back(make_frame(me, OP_START, 8'd2, 16'h0123));
    frame_q.push_back(make_frame(me, OP_PING, 8'd0, 16'h0000));
    frame_q.push_back(make_frame(me, OP_ESTOP, 8'd0, 16'h0000));
    push_random(150);
    wait_drained();

    write_reg(CFG_NODE_ID, 11'($urandom_range(2047)));
    write_reg(CFG_CMD_BASE, 11'($urandom_range(2047)));
    write_reg(CFG_ACK_BASE, 11'($urandom_range(2047)));
    @(negedge clk_i);
    push_random(150);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (err_count == 0 && decoded_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ccd_pkg.sv
design/ccd_decode.sv
design/can_channel_command_decoder_top.sv
sim/tb.sv
